// ===== rtl/core/sas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_pkg
// Shared types, constants and helpers of the sunrise alarm scheduler.
// ----------------------------------------------------------------------------
package sas_pkg;

    localparam int ALARM_COUNT = 8;
    localparam int IDX_W       = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;
    localparam int MIN_W       = 11;
    localparam int DIV_STEPS   = 9;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 24;

    localparam logic [MIN_W-1:0] MINUTES_PER_DAY = 11'd1440;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_VALIDATE = 2'd1,
        OP_WRITE    = 2'd2,
        OP_SPARE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_START_BRIGHTNESS = 2'd0,
        REG_MAX_BRIGHTNESS   = 2'd1,
        REG_FULL_LIGHT_MIN   = 2'd2,
        REG_NONE             = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_ACK,
        ST_SCAN,
        ST_SCAN_END,
        ST_EVAL,
        ST_DIV,
        ST_MUL,
        ST_LEVEL,
        ST_RING,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [7:0] rise;
        logic [2:0] sound;
        logic [6:0] days;
        logic       enable;
    } alarm_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic prep;
        logic ack_ring;
        logic scan;
        logic ack_best;
        logic eval;
        logic mul;
        logic level;
        logic ring;
        logic out_load;
        logic idx_clr;
        logic idx_inc;
    } sas_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        op_t  op;
        logic any_ring;
        logic last_idx;
        logic need_div;
        logic div_done;
    } sas_stat_t;

    // hour * 60 + minute as shift and subtract
    function automatic logic [MIN_W-1:0] to_minutes(input logic [4:0] hour,
                                                    input logic [5:0] minute);
        logic [MIN_W-1:0] h;
        h = MIN_W'(hour);
        return (h << 6) - (h << 2) + MIN_W'(minute);
    endfunction

endpackage

// ===== rtl/core/sas_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_ctrl
// Sequencer: walks the alarm table for acknowledge, evaluation and ringing.
// ----------------------------------------------------------------------------
module sas_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  sas_pkg::sas_stat_t stat,
    output sas_pkg::sas_cmd_t  cmd
);

    sas_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sas_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == sas_pkg::ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            sas_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sas_pkg::ST_PREP;
                end
            end
            sas_pkg::ST_PREP:
            begin
                cmd.idx_clr = 1'b1;
                if (stat.op == sas_pkg::OP_WRITE)
                    state_next = sas_pkg::ST_FINISH;
                else
                begin
                    cmd.prep   = 1'b1;
                    state_next = (stat.op == sas_pkg::OP_VALIDATE) ? sas_pkg::ST_ACK
                                                                  : sas_pkg::ST_EVAL;
                end
            end
            sas_pkg::ST_ACK:
            begin
                if (stat.any_ring)
                begin
                    cmd.ack_ring = 1'b1;
                    state_next   = sas_pkg::ST_EVAL;
                end
                else
                    state_next = sas_pkg::ST_SCAN;
            end
            sas_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.last_idx)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = sas_pkg::ST_SCAN_END;
                end
                else
                    cmd.idx_inc = 1'b1;
            end
            sas_pkg::ST_SCAN_END:
            begin
                cmd.ack_best = 1'b1;
                state_next   = sas_pkg::ST_EVAL;
            end
            sas_pkg::ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (stat.need_div)
                    state_next = sas_pkg::ST_DIV;
                else if (stat.last_idx)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = sas_pkg::ST_LEVEL;
                end
                else
                    cmd.idx_inc = 1'b1;
            end
            sas_pkg::ST_DIV:
            begin
                if (stat.div_done)
                    state_next = sas_pkg::ST_MUL;
            end
            sas_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
                if (stat.last_idx)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = sas_pkg::ST_LEVEL;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = sas_pkg::ST_EVAL;
                end
            end
            sas_pkg::ST_LEVEL:
            begin
                cmd.level  = 1'b1;
                state_next = sas_pkg::ST_RING;
            end
            sas_pkg::ST_RING:
            begin
                cmd.ring = 1'b1;
                if (stat.last_idx)
                    state_next = sas_pkg::ST_FINISH;
                else
                    cmd.idx_inc = 1'b1;
            end
            sas_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = sas_pkg::ST_IDLE;
                end
            end
            default:
                state_next = sas_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/sas_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_dp
// Datapath: alarm table, marks, ramp divider and multiplier, result word.
// ----------------------------------------------------------------------------
module sas_dp
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [sas_pkg::IN_DATA_W-1:0]    in_data,
    input  logic [1:0]                       in_op,
    input  logic                             cfg_valid,
    input  logic [1:0]                       cfg_index,
    input  logic [7:0]                       cfg_data,
    input  sas_pkg::sas_cmd_t                cmd,
    output sas_pkg::sas_stat_t               stat,
    output logic [sas_pkg::OUT_DATA_W-1:0]   out_data
);

    // configuration
    logic [7:0] start_b_reg, max_b_reg, flm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_b_reg <= 8'd0;
            max_b_reg   <= 8'd255;
            flm_reg     <= 8'd5;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sas_pkg::REG_START_BRIGHTNESS: start_b_reg <= cfg_data;
                sas_pkg::REG_MAX_BRIGHTNESS:   max_b_reg   <= cfg_data;
                sas_pkg::REG_FULL_LIGHT_MIN:   flm_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // latched tick fields
    logic [1:0] op_reg;
    logic [2:0] wd_reg;
    logic [4:0] dom_reg;
    logic [4:0] hour_reg;
    logic [5:0] minute_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_op;
            wd_reg     <= in_data[2:0];
            dom_reg    <= in_data[7:3];
            hour_reg   <= in_data[12:8];
            minute_reg <= in_data[18:13];
        end
    end

    logic [2:0]             e_index;
    sas_pkg::alarm_t        e_new;
    assign e_index       = in_data[21:19];
    assign e_new.hour    = in_data[26:22];
    assign e_new.minute  = in_data[32:27];
    assign e_new.rise    = in_data[40:33];
    assign e_new.sound   = in_data[43:41];
    assign e_new.days    = in_data[50:44];
    assign e_new.enable  = in_data[51];

    // alarm table and marks
    sas_pkg::alarm_t table_reg [sas_pkg::ALARM_COUNT];
    logic [sas_pkg::ALARM_COUNT-1:0] handled_reg, ringing_reg, due_reg;
    logic [7:0] last_day_reg, held_reg;
    logic [sas_pkg::IDX_W-1:0] idx_reg, best_idx_reg, ring_idx_reg;
    logic [sas_pkg::MIN_W-1:0] best_time_reg;
    logic found_reg;
    logic active_reg, changed_reg, started_reg, stopped_reg;
    logic [2:0] ring_snd_reg;
    logic [7:0] highest_reg, elapsed_reg, divisor_reg, rem_reg;
    logic [8:0] quo_reg;
    logic [3:0] div_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sas_pkg::ALARM_COUNT; i++)
                table_reg[i] <= '0;
        end
        else if (cmd.load && in_op == sas_pkg::OP_WRITE
                 && 32'(e_index) < sas_pkg::ALARM_COUNT)
            table_reg[sas_pkg::IDX_W'(e_index)] <= e_new;
    end

    // classification of the entry under the walk pointer
    sas_pkg::alarm_t        cur;
    logic [sas_pkg::MIN_W-1:0] now_min, am;
    logic [sas_pkg::MIN_W:0]   now_rise;
    logic day_ok, elig, started_phase, sunrise, due;
    logic [7:0] ramp, elapsed;
    logic direct_max, need_div;
    logic [8:0] numer;

    assign cur      = table_reg[idx_reg];
    assign now_min  = sas_pkg::to_minutes(hour_reg, minute_reg);
    assign am       = sas_pkg::to_minutes(cur.hour, cur.minute);
    assign now_rise = {1'b0, now_min} + (sas_pkg::MIN_W+1)'(cur.rise);
    assign day_ok   = (wd_reg < 3'd7) && ((({1'b0, cur.days}) >> wd_reg) & 8'd1) != 8'd0;
    assign elig     = cur.enable && day_ok && !handled_reg[idx_reg];
    assign started_phase = now_rise >= {1'b0, am};
    assign sunrise  = elig && started_phase && (now_min < am);
    assign due      = elig && started_phase && (now_min >= am);
    assign ramp     = cur.rise - flm_reg;
    assign elapsed  = 8'(now_rise - {1'b0, am});
    assign direct_max = (cur.rise <= flm_reg) || (elapsed >= ramp)
                        || (start_b_reg >= max_b_reg);
    assign need_div = sunrise && !direct_max;
    assign numer    = {1'b0, max_b_reg} - {1'b0, start_b_reg} + {1'b0, ramp} - 9'd1;

    // lowest ringing entry
    logic [sas_pkg::IDX_W-1:0] ring_first;
    always_comb
    begin
        ring_first = '0;
        for (int i = sas_pkg::ALARM_COUNT - 1; i >= 0; i--)
            if (ringing_reg[i])
                ring_first = sas_pkg::IDX_W'(i);
    end

    // divider step and ramp product
    logic [8:0]  div_t;
    logic [15:0] prod;
    logic [16:0] lvl_wide;
    logic [7:0]  lvl;
    assign div_t    = {rem_reg, quo_reg[8]};
    assign prod     = elapsed_reg * quo_reg[7:0];
    assign lvl_wide = 17'(start_b_reg) + 17'(prod);
    assign lvl      = (lvl_wide > 17'(max_b_reg)) ? max_b_reg : lvl_wide[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            handled_reg  <= '0;
            ringing_reg  <= '0;
            last_day_reg <= 8'd255;
            held_reg     <= 8'd0;
            idx_reg      <= '0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;

            if (cmd.prep && {3'd0, dom_reg} != last_day_reg)
            begin
                last_day_reg <= {3'd0, dom_reg};
                handled_reg  <= '0;
                ringing_reg  <= '0;
            end
            if (cmd.ack_ring)
            begin
                handled_reg[ring_first] <= 1'b1;
                ringing_reg[ring_first] <= 1'b0;
            end
            if (cmd.ack_best && found_reg)
            begin
                handled_reg[best_idx_reg] <= 1'b1;
                ringing_reg[best_idx_reg] <= 1'b0;
            end
            if (cmd.ring && due_reg[idx_reg] && !handled_reg[idx_reg] && !(|ringing_reg))
                ringing_reg[idx_reg] <= 1'b1;
            if (cmd.level && active_reg && highest_reg != held_reg)
                held_reg <= highest_reg;

            if (cmd.eval && need_div)
                div_cnt_reg <= 4'(sas_pkg::DIV_STEPS);
            else if (div_cnt_reg != 4'd0)
                div_cnt_reg <= div_cnt_reg - 4'd1;
        end
    end

    // per-item working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            active_reg    <= 1'b0;
            changed_reg   <= 1'b0;
            started_reg   <= 1'b0;
            stopped_reg   <= 1'b0;
            ring_idx_reg  <= '0;
            ring_snd_reg  <= 3'd0;
            found_reg     <= 1'b0;
            best_time_reg <= sas_pkg::MINUTES_PER_DAY;
            best_idx_reg  <= '0;
            highest_reg   <= start_b_reg;
        end
        if (cmd.ack_ring || (cmd.ack_best && found_reg))
            stopped_reg <= 1'b1;
        if (cmd.scan && sunrise && am < best_time_reg)
        begin
            best_time_reg <= am;
            best_idx_reg  <= idx_reg;
            found_reg     <= 1'b1;
        end
        if (cmd.eval)
        begin
            due_reg[idx_reg] <= due;
            elapsed_reg      <= elapsed;
            if (sunrise)
            begin
                active_reg <= 1'b1;
                if (direct_max && max_b_reg > highest_reg)
                    highest_reg <= max_b_reg;
            end
            if (need_div)
            begin
                quo_reg     <= numer;
                rem_reg     <= 8'd0;
                divisor_reg <= ramp;
            end
        end
        else if (div_cnt_reg != 4'd0)
        begin
            if (div_t >= {1'b0, divisor_reg})
            begin
                rem_reg <= 8'(div_t - {1'b0, divisor_reg});
                quo_reg <= {quo_reg[7:0], 1'b1};
            end
            else
            begin
                rem_reg <= div_t[7:0];
                quo_reg <= {quo_reg[7:0], 1'b0};
            end
        end
        if (cmd.mul && lvl > highest_reg)
            highest_reg <= lvl;
        if (cmd.level && active_reg && highest_reg != held_reg)
            changed_reg <= 1'b1;
        if (cmd.ring && due_reg[idx_reg] && !handled_reg[idx_reg] && !(|ringing_reg))
        begin
            started_reg  <= 1'b1;
            ring_idx_reg <= idx_reg;
            ring_snd_reg <= cur.sound;
        end
    end

    // result word
    logic [sas_pkg::OUT_DATA_W-1:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_reg <= {6'd0, stopped_reg, ring_snd_reg, 3'(ring_idx_reg), started_reg,
                        changed_reg, held_reg, active_reg};
    end
    assign out_data = out_reg;

    assign stat.op       = sas_pkg::op_t'(op_reg);
    assign stat.any_ring = |ringing_reg;
    assign stat.last_idx = (idx_reg == sas_pkg::IDX_W'(sas_pkg::ALARM_COUNT - 1));
    assign stat.need_div = need_div;
    assign stat.div_done = (div_cnt_reg == 4'd0);

endmodule

// ===== rtl/core/sunrise_alarm_scheduler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sunrise_alarm_scheduler_unit
// Eight-entry sunrise alarm scheduler driven by minute ticks.
// ----------------------------------------------------------------------------
// One word in gives one result word out. An entry write passes the accept
// and prep states to the result hand-off. A tick runs through accept, day
// check, one table entry a cycle for evaluation (held while a ramp step is
// divided), a level update, one entry a cycle for the ringing walk, and the
// result hand-off. A validate press adds a ringing check, and an earliest-
// sunrise search over the table when nothing rings. For each alarm in the
// middle of its ramp the ramp step comes from a 9-step bit-serial divider
// with a done check, followed by a multiply step.
// A new word is taken only once the previous one has been handed to the
// output register, which holds one finished result while the next is
// worked on. Configuration writes are always taken and should only be
// issued while the block is idle.
module sunrise_alarm_scheduler_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // weekday, day_of_month, now_hour, now_minute, entry_index, entry_hour,
    // entry_minute, entry_rise, entry_sound, entry_days, entry_enable
    input  logic [55:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,   // op
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // sunrise_on, light_level, level_changed, ring_start, ring_index,
    // ring_sound, sound_stop
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    sas_pkg::sas_cmd_t  cmd;
    sas_pkg::sas_stat_t stat;

    assign cfg_ready = 1'b1;

    // sequencer
    sas_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // table, marks, ramp arithmetic and result register
    sas_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .in_op     (s_axis_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== rtl/core/sas_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_checker
// Port-level checks for the sunrise alarm scheduler.
// ----------------------------------------------------------------------------
module sas_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // one word in flight: busy right after acceptance
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("word accepted while busy");

    // no ring: index and sound zero
    a_ring_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[10] |-> m_axis_tdata[16:11] == 6'd0)
        else $error("ring fields set without ring start");

    // a level update only happens during a sunrise
    a_level_sunrise: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[0])
        else $error("level changed without sunrise");

endmodule

bind sunrise_alarm_scheduler_unit sas_checker u_sas_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

// ===== tb/sunrise_alarm_scheduler_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sunrise_alarm_scheduler_unit_tb
// Self-checking bench for the sunrise alarm scheduler. Table writes and
// minute ticks go in as stream words; every result word is checked against
// a predictor of the alarm table, day marks and held light level. Several
// brightness settings are visited, one of them at the extremes.
// ----------------------------------------------------------------------------
module sunrise_alarm_scheduler_unit_tb;

    localparam int CYCLE_LIMIT = 400000;

    // one input word, split into fields (op in the lowest bits)
    typedef struct packed {
        logic       e_enable;
        logic [6:0] e_days;
        logic [2:0] e_sound;
        logic [7:0] e_rise;
        logic [5:0] e_minute;
        logic [4:0] e_hour;
        logic [2:0] idx;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [2:0] weekday;
        logic [1:0] op;
    } tick_word_t;

    // result word, sunrise_on in the lowest bit
    typedef struct packed {
        logic       sound_stop;
        logic [2:0] ring_sound;
        logic [2:0] ring_index;
        logic       ring_start;
        logic       level_changed;
        logic [7:0] light_level;
        logic       sunrise_on;
    } result_word_t;

    logic        clk;
    logic        rst_n;
    logic [55:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    sunrise_alarm_scheduler_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ---- predictor state -------------------------------------------------
    sas_pkg::alarm_t alarms  [sas_pkg::ALARM_COUNT];
    logic       handled  [sas_pkg::ALARM_COUNT];
    logic       ringing  [sas_pkg::ALARM_COUNT];
    logic [7:0] last_day;
    logic [7:0] held_lvl;
    logic [7:0] start_lvl;
    logic [7:0] max_lvl;
    logic [7:0] full_mins;

    tick_word_t   pending_words [$];
    result_word_t awaited       [$];

    int  mismatches = 0;
    int  words_sent = 0;
    int  results_seen = 0;
    int  rings_seen = 0;
    int  stops_seen = 0;
    int  cycles = 0;
    bit  stim_done;
    bit  hold_off;
    int  rx_gap;
    int  tx_gap;

    // ---- clock and cycle limit ------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL sunrise_alarm_scheduler_unit");
            $finish;
        end
    end

    function automatic int alarm_time(int i);
        return alarms[i].hour * 60 + alarms[i].minute;
    endfunction

    // 0 inactive, 1 in sunrise, 2 due
    function automatic int alarm_phase(int i, int wd, int now);
        int begin_at;
        if (!alarms[i].enable || wd > 6 || !alarms[i].days[wd] || handled[i])
            return 0;
        begin_at = alarm_time(i) - alarms[i].rise;
        if (now < begin_at)
            return 0;
        if (now < alarm_time(i))
            return 1;
        return 2;
    endfunction

    function automatic int ramp_of(int i, int now);
        int rise;
        int ramp;
        int elapsed;
        int step;
        int lvl;
        rise = alarms[i].rise;
        if (rise <= full_mins)
            return max_lvl;
        ramp    = rise - full_mins;
        elapsed = now + rise - alarm_time(i);
        if (elapsed >= ramp || start_lvl >= max_lvl)
            return max_lvl;
        step = (max_lvl - start_lvl + ramp - 1) / ramp;
        lvl  = start_lvl + elapsed * step;
        return (lvl > max_lvl) ? max_lvl : lvl;
    endfunction

    // Advance the scheduler state by one word and give its result.
    function automatic result_word_t schedule_word(tick_word_t w);
        result_word_t r;
        int  phase [sas_pkg::ALARM_COUNT];
        int  now;
        int  highest;
        int  best_t;
        int  best;
        bit  done;
        bit  busy;
        r   = '0;
        now = w.hour * 60 + w.minute;
        if (w.op == sas_pkg::OP_WRITE)
        begin
            alarms[w.idx] = {w.e_hour, w.e_minute, w.e_rise, w.e_sound, w.e_days,
                             w.e_enable};
            r.light_level = held_lvl;
            return r;
        end
        if ({3'b0, w.day} != last_day)
        begin
            last_day = {3'b0, w.day};
            for (int i = 0; i < sas_pkg::ALARM_COUNT; i++)
            begin
                handled[i] = 1'b0;
                ringing[i] = 1'b0;
            end
        end
        if (w.op == sas_pkg::OP_VALIDATE)
        begin
            done = 1'b0;
            for (int i = 0; i < sas_pkg::ALARM_COUNT && !done; i++)
                if (ringing[i])
                begin
                    handled[i]   = 1'b1;
                    ringing[i]   = 1'b0;
                    r.sound_stop = 1'b1;
                    done         = 1'b1;
                end
            if (!done)
            begin
                best_t = 1440;
                best   = -1;
                for (int i = 0; i < sas_pkg::ALARM_COUNT; i++)
                    if (alarm_phase(i, w.weekday, now) == 1 && alarm_time(i) < best_t)
                    begin
                        best_t = alarm_time(i);
                        best   = i;
                    end
                if (best >= 0)
                begin
                    handled[best] = 1'b1;
                    ringing[best] = 1'b0;
                    r.sound_stop  = 1'b1;
                end
            end
        end
        highest = start_lvl;
        for (int i = 0; i < sas_pkg::ALARM_COUNT; i++)
        begin
            phase[i] = alarm_phase(i, w.weekday, now);
            if (phase[i] == 1)
            begin
                r.sunrise_on = 1'b1;
                if (ramp_of(i, now) > highest)
                    highest = ramp_of(i, now);
            end
        end
        if (r.sunrise_on && highest != held_lvl)
        begin
            held_lvl        = 8'(highest);
            r.level_changed = 1'b1;
        end
        for (int i = 0; i < sas_pkg::ALARM_COUNT; i++)
        begin
            if (phase[i] != 2 || handled[i])
                continue;
            busy = 1'b0;
            for (int k = 0; k < sas_pkg::ALARM_COUNT; k++)
                busy |= ringing[k];
            if (busy)
                continue;
            ringing[i]   = 1'b1;
            r.ring_start = 1'b1;
            r.ring_index = 3'(i);
            r.ring_sound = alarms[i].sound;
        end
        r.light_level = held_lvl;
        return r;
    endfunction

    // ---- driver: feeds words from the pending queue with random gaps -----
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            tx_gap        <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            // previous word (if any) taken this edge; predict it
            if (s_axis_tvalid)
            begin
                awaited.push_back(schedule_word(pending_words.pop_front()));
                words_sent <= words_sent + 1;
            end
            if (tx_gap > 0)
            begin
                tx_gap        <= tx_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                tick_word_t nw;
                nw = pending_words[0];
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= nw.op;
                s_axis_tdata  <= 56'(nw[53:2]);
                tx_gap <= ($urandom_range(0, 3) == 0) ?
                          (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 3)) : 0;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ---- monitor: random back-pressure, checks each result word ----------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_gap        <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                result_word_t got;
                result_word_t want;
                got = m_axis_tdata[17:0];
                results_seen <= results_seen + 1;
                if (awaited.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result word %h", got);
                end
                else
                begin
                    want = awaited.pop_front();
                    rings_seen <= rings_seen + got.ring_start;
                    stops_seen <= stops_seen + got.sound_stop;
                    if (got !== want)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: want on=%b lvl=%0d chg=%b ring=%b/%0d/%0d stop=%b, got on=%b lvl=%0d chg=%b ring=%b/%0d/%0d stop=%b",
                                want.sunrise_on, want.light_level, want.level_changed,
                                want.ring_start, want.ring_index, want.ring_sound,
                                want.sound_stop, got.sunrise_on, got.light_level,
                                got.level_changed, got.ring_start, got.ring_index,
                                got.ring_sound, got.sound_stop);
                    end
                end
            end
            if (hold_off)
                m_axis_tready <= 1'b0;
            else if (rx_gap > 0)
            begin
                rx_gap        <= rx_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 4) == 0)
                    rx_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                          : $urandom_range(1, 4);
            end
        end
    end

    // ---- stimulus helpers ------------------------------------------------
    function automatic tick_word_t make_tick(logic [1:0] op, int wd, int day, int hr,
                                             int mn);
        tick_word_t w;
        w         = '0;
        w.op      = op;
        w.weekday = 3'(wd);
        w.day     = 5'(day);
        w.hour    = 5'(hr);
        w.minute  = 6'(mn);
        // unused entry bits carry noise so every data bit toggles
        w.idx = 3'($urandom);  w.e_hour = 5'($urandom);  w.e_minute = 6'($urandom);
        w.e_rise = 8'($urandom);  w.e_sound = 3'($urandom);  w.e_days = 7'($urandom);
        w.e_enable = 1'($urandom);
        return w;
    endfunction

    function automatic tick_word_t make_entry(int idx, int hr, int mn, int rise, int snd,
                                              int days, bit en);
        tick_word_t w;
        w          = make_tick(sas_pkg::OP_WRITE, $urandom_range(0, 7), $urandom,
                               $urandom, $urandom);
        w.idx      = 3'(idx);
        w.e_hour   = 5'(hr);
        w.e_minute = 6'(mn);
        w.e_rise   = 8'(rise);
        w.e_sound  = 3'(snd);
        w.e_days   = 7'(days);
        w.e_enable = en;
        return w;
    endfunction

    function automatic tick_word_t random_entry();
        return make_entry($urandom_range(0, 7),
                          ($urandom_range(0, 15) == 0) ? $urandom_range(24, 31)
                                                       : $urandom_range(0, 23),
                          ($urandom_range(0, 15) == 0) ? $urandom_range(60, 63)
                                                       : $urandom_range(0, 59),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 40),
                          $urandom_range(0, 7), $urandom_range(0, 127),
                          $urandom_range(0, 7) != 0);
    endfunction

    task automatic wait_drained();
        while (pending_words.size() != 0 || s_axis_tvalid || awaited.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(sas_pkg::reg_idx_t idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            sas_pkg::REG_START_BRIGHTNESS: start_lvl = val;
            sas_pkg::REG_MAX_BRIGHTNESS:   max_lvl   = val;
            sas_pkg::REG_FULL_LIGHT_MIN:   full_mins = val;
            default: ;
        endcase
    endtask

    // A burst of days: a few table writes, then a run of minute ticks
    // walking across the alarm times, with validate presses mixed in.
    task automatic queue_day_run(int n_ticks);
        int t;
        int wd;
        int day;
        int step;
        tick_word_t w;
        wd   = $urandom_range(0, 6);
        day  = $urandom_range(1, 31);
        t    = $urandom_range(0, 1439);
        for (int k = 0; k < $urandom_range(1, 3); k++)
            pending_words.push_back(random_entry());
        for (int k = 0; k < n_ticks; k++)
        begin
            step = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 90) : $urandom_range(1, 4);
            t = t + step;
            if (t >= 1440)
            begin
                t   = t - 1440;
                wd  = (wd + 1) % 7;
                day = (day % 31) + 1;
            end
            case ($urandom_range(0, 19))
                0:       w = make_tick(sas_pkg::OP_SPARE, wd, day, t / 60, t % 60);
                1:       w = make_tick(sas_pkg::OP_TICK, 7, day, t / 60, t % 60);
                2:       w = make_tick(sas_pkg::OP_TICK, wd, day, $urandom_range(24, 31),
                                       $urandom_range(0, 63));
                3, 4, 5: w = make_tick(sas_pkg::OP_VALIDATE, wd, day, t / 60, t % 60);
                6:       w = random_entry();
                default: w = make_tick(sas_pkg::OP_TICK, wd, day, t / 60, t % 60);
            endcase
            pending_words.push_back(w);
        end
    endtask

    // ---- main sequence ---------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = sas_pkg::REG_START_BRIGHTNESS;
        cfg_data   = '0;
        hold_off   = 1'b0;
        stim_done  = 1'b0;
        for (int i = 0; i < sas_pkg::ALARM_COUNT; i++)
        begin
            alarms[i]  = '0;
            handled[i] = 1'b0;
            ringing[i] = 1'b0;
        end
        last_day  = 8'd255;
        held_lvl  = 8'd0;
        start_lvl = 8'd0;
        max_lvl   = 8'd255;
        full_mins = 8'd5;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, sunrise, ring, press, odd cases
        pending_words.push_back(make_tick(sas_pkg::OP_TICK, 1, 1, 6, 0));
        pending_words.push_back(make_entry(0, 7, 0, 30, 3, 7'h7f, 1'b1));
        pending_words.push_back(make_entry(1, 6, 50, 255, 0, 7'h02, 1'b1));
        pending_words.push_back(make_entry(7, 31, 63, 0, 7, 7'h7f, 1'b1));
        pending_words.push_back(make_entry(2, 23, 59, 3, 6, 7'h01, 1'b0));
        pending_words.push_back(make_tick(sas_pkg::OP_TICK, 1, 1, 6, 35));
        pending_words.push_back(make_tick(sas_pkg::OP_TICK, 1, 1, 6, 45));
        pending_words.push_back(make_tick(sas_pkg::OP_VALIDATE, 1, 1, 6, 46));
        pending_words.push_back(make_tick(sas_pkg::OP_TICK, 1, 1, 6, 58));
        pending_words.push_back(make_tick(sas_pkg::OP_TICK, 1, 1, 7, 0));
        pending_words.push_back(make_tick(sas_pkg::OP_TICK, 1, 1, 7, 1));
        pending_words.push_back(make_tick(sas_pkg::OP_VALIDATE, 1, 1, 7, 2));
        pending_words.push_back(make_tick(sas_pkg::OP_SPARE, 1, 1, 7, 3));
        pending_words.push_back(make_tick(sas_pkg::OP_TICK, 7, 2, 6, 59));
        pending_words.push_back(make_tick(sas_pkg::OP_TICK, 2, 2, 31, 63));
        pending_words.push_back(make_tick(sas_pkg::OP_VALIDATE, 2, 2, 31, 63));
        pending_words.push_back(make_tick(sas_pkg::OP_TICK, 0, 31, 0, 0));
        wait_drained();

        // phases over brightness settings, one of them at the extremes
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin write_reg(sas_pkg::REG_START_BRIGHTNESS, 8'd20);
                         write_reg(sas_pkg::REG_MAX_BRIGHTNESS, 8'd200);
                         write_reg(sas_pkg::REG_FULL_LIGHT_MIN, 8'd0); end
                1: begin write_reg(sas_pkg::REG_START_BRIGHTNESS, 8'd255);
                         write_reg(sas_pkg::REG_MAX_BRIGHTNESS, 8'd0);
                         write_reg(sas_pkg::REG_FULL_LIGHT_MIN, 8'd255); end
                2: begin write_reg(sas_pkg::REG_START_BRIGHTNESS, 8'd0);
                         write_reg(sas_pkg::REG_MAX_BRIGHTNESS, 8'd255);
                         write_reg(sas_pkg::REG_FULL_LIGHT_MIN, 8'd3); end
                3: begin write_reg(sas_pkg::REG_START_BRIGHTNESS, 8'($urandom));
                         write_reg(sas_pkg::REG_MAX_BRIGHTNESS, 8'($urandom));
                         write_reg(sas_pkg::REG_FULL_LIGHT_MIN,
                                   8'($urandom_range(0, 20))); end
                default: begin write_reg(sas_pkg::REG_START_BRIGHTNESS, 8'd100);
                         write_reg(sas_pkg::REG_MAX_BRIGHTNESS, 8'd100);
                         write_reg(sas_pkg::REG_FULL_LIGHT_MIN, 8'd1); end
            endcase
            for (int r = 0; r < 4; r++)
                queue_day_run(18);
            if (ph == 2)
            begin
                // receiver stalls long while words keep coming
                hold_off = 1'b1;
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            wait_drained();
        end
        stim_done = 1'b1;

        $display("covered %0d words, %0d results, %0d alarm starts, %0d presses that stopped",
                 words_sent, results_seen, rings_seen, stops_seen);
        $display("five brightness settings incl. start above max and zero hold time");
        if (mismatches == 0)
            $display("PASS sunrise_alarm_scheduler_unit");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("FAIL sunrise_alarm_scheduler_unit");
        end
        $finish;
    end

endmodule
